// ===== hdl/hmt_pkg.sv =====
// Shared types, widths and codes of the heartbeat membership table.
package hmt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W    = 32;
    localparam int PORT_W  = 16;
    localparam int BEAT_W  = 32;
    localparam int STAMP_W = 32;
    localparam int TMO_W   = 16;
    localparam int EV_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // result event codes
    localparam logic [EV_W-1:0] EV_ADDED     = 3'd0;
    localparam logic [EV_W-1:0] EV_REFRESHED = 3'd1;
    localparam logic [EV_W-1:0] EV_IGNORED   = 3'd2;
    localparam logic [EV_W-1:0] EV_FULL      = 3'd3;
    localparam logic [EV_W-1:0] EV_SUSPECT   = 3'd4;
    localparam logic [EV_W-1:0] EV_REMOVED   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TMO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_TMO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT   = 2'd3;

    localparam logic [TMO_W-1:0]  FAIL_TMO_RST   = 16'd5;
    localparam logic [TMO_W-1:0]  REMOVE_TMO_RST = 16'd20;
    localparam logic [ID_W-1:0]   OWN_ID_RST     = 32'd1;
    localparam logic [PORT_W-1:0] OWN_PORT_RST   = 16'd0;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PORT_W-1:0]  port;
        logic [BEAT_W-1:0]  beat;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_MOVE
    } state_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_ZERO,
        RD_NEXT,
        RD_LAST
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_REFRESH,
        WR_INSERT,
        WR_MOVE
    } wr_op_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ITEM_NOBEAT,
        SRC_ITEM,
        SRC_ENTRY
    } out_src_t;

    typedef struct packed {
        logic            load;
        idx_op_t         idx_op;
        logic            rd_en;
        rd_sel_t         rd_sel;
        wr_op_t          wr_op;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            emit;
        logic [EV_W-1:0] ev;
        logic            done;
        logic            last;
        out_src_t        src;
    } cmd_t;

    typedef struct packed {
        logic is_self;
        logic at_end;
        logic full;
        logic match;
        logic newer;
        logic over_fail;
        logic over_remove;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/heartbeat_membership_table.sv =====
// Heartbeat membership table top level: sequencer plus datapath.
// Report beat: the table is searched from entry 0 until the member's address is found or
//   the end is reached; our own address is answered as ignored without a search.
// Tick beat: entries are checked in order and a done beat ends the sweep; one entry read
//   per cycle while no result waits on a full output register, a removal adds a move step to fill the hole.
// A new input beat is taken once the last result of the item is registered; a result
//   that waits on a full output register holds it back.
// Reset (aresetn low, synchronous): table empty, tick count zero, config to defaults;
//   entry memory itself is not cleared.
module heartbeat_membership_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats: reports (mode 0) and ticks (mode 1)
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [hmt_pkg::ID_W-1:0]        s_member_id,
    input  logic [hmt_pkg::PORT_W-1:0]      s_member_port,
    input  logic [hmt_pkg::BEAT_W-1:0]      s_member_beat,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hmt_pkg::EV_W-1:0]        m_event_res,
    output logic                            m_sweep_done,
    output logic [hmt_pkg::ID_W-1:0]        m_out_id,
    output logic [hmt_pkg::PORT_W-1:0]      m_out_port,
    output logic [hmt_pkg::BEAT_W-1:0]      m_out_beat,
    output logic                            m_last
);

    // Sequencer and datapath talk only through these two bundles.
    // The datapath keeps the next entry read ahead, so a scan step that
    // does not stall advances one entry a cycle. A result waits in a single
    // output register; while it is held, a step that must emit re-reads the current
    // entry and holds position.
    hmt_pkg::cmd_t cmd;
    hmt_pkg::sts_t sts;

    hmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, counters, timeouts, own address and result register.
    hmt_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_member_id   (s_member_id),
        .s_member_port (s_member_port),
        .s_member_beat (s_member_beat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_sweep_done  (m_sweep_done),
        .m_out_id      (m_out_id),
        .m_out_port    (m_out_port),
        .m_out_beat    (m_out_beat),
        .m_last        (m_last)
    );

endmodule

// ===== hdl/hmt_ctrl.sv =====
// Sequencer of the membership table: search, insert, sweep and removal steps.
module hmt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_mode,
    input  hmt_pkg::sts_t  sts,
    output hmt_pkg::cmd_t  cmd
);

    hmt_pkg::state_t state_reg;
    hmt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hmt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == hmt_pkg::ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hmt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_mode ? hmt_pkg::ST_SWEEP : hmt_pkg::ST_SEARCH;
                end
            end
            hmt_pkg::ST_SEARCH: begin
                if (sts.out_free && (sts.is_self || sts.at_end || sts.match)) begin
                    state_next = hmt_pkg::ST_IDLE;
                end
            end
            hmt_pkg::ST_SWEEP: begin
                if (sts.out_free) begin
                    if (sts.at_end) begin
                        state_next = hmt_pkg::ST_IDLE;
                    end else if (sts.over_fail && sts.over_remove) begin
                        state_next = hmt_pkg::ST_MOVE;
                    end
                end
            end
            hmt_pkg::ST_MOVE: begin
                state_next = hmt_pkg::ST_SWEEP;
            end
            default: begin
                state_next = hmt_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        cmd.load    = 1'b0;
        cmd.idx_op  = hmt_pkg::IDX_HOLD;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = hmt_pkg::RD_IDX;
        cmd.wr_op   = hmt_pkg::WR_NONE;
        cmd.cnt_inc = 1'b0;
        cmd.cnt_dec = 1'b0;
        cmd.emit    = 1'b0;
        cmd.ev      = hmt_pkg::EV_ADDED;
        cmd.done    = 1'b0;
        cmd.last    = 1'b0;
        cmd.src     = hmt_pkg::SRC_ZERO;
        case (state_reg)
            hmt_pkg::ST_IDLE: begin
                // keep entry 0 primed in the read register for the first compare
                cmd.rd_sel = hmt_pkg::RD_ZERO;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cmd.idx_op = hmt_pkg::IDX_ZERO;
                end
            end
            hmt_pkg::ST_SEARCH: begin
                if (sts.is_self) begin
                    if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.ev   = hmt_pkg::EV_IGNORED;
                        cmd.last = 1'b1;
                        cmd.src  = hmt_pkg::SRC_ITEM_NOBEAT;
                    end
                end else if (sts.at_end) begin
                    if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        if (sts.full) begin
                            cmd.ev  = hmt_pkg::EV_FULL;
                            cmd.src = hmt_pkg::SRC_ITEM_NOBEAT;
                        end else begin
                            cmd.ev      = hmt_pkg::EV_ADDED;
                            cmd.src     = hmt_pkg::SRC_ITEM;
                            cmd.wr_op   = hmt_pkg::WR_INSERT;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                end else if (sts.match) begin
                    if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        if (sts.newer) begin
                            cmd.ev    = hmt_pkg::EV_REFRESHED;
                            cmd.src   = hmt_pkg::SRC_ITEM;
                            cmd.wr_op = hmt_pkg::WR_REFRESH;
                        end else begin
                            cmd.ev  = hmt_pkg::EV_IGNORED;
                            cmd.src = hmt_pkg::SRC_ENTRY;
                        end
                    end
                end else begin
                    cmd.idx_op = hmt_pkg::IDX_INC;
                    cmd.rd_sel = hmt_pkg::RD_NEXT;
                end
            end
            hmt_pkg::ST_SWEEP: begin
                if (sts.at_end) begin
                    if (sts.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.done = 1'b1;
                        cmd.last = 1'b1;
                        cmd.src  = hmt_pkg::SRC_ZERO;
                    end
                end else if (!sts.over_fail) begin
                    cmd.idx_op = hmt_pkg::IDX_INC;
                    cmd.rd_sel = hmt_pkg::RD_NEXT;
                end else if (!sts.over_remove) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.ev     = hmt_pkg::EV_SUSPECT;
                        cmd.src    = hmt_pkg::SRC_ENTRY;
                        cmd.idx_op = hmt_pkg::IDX_INC;
                        cmd.rd_sel = hmt_pkg::RD_NEXT;
                    end
                end else begin
                    if (sts.out_free) begin
                        cmd.emit    = 1'b1;
                        cmd.ev      = hmt_pkg::EV_REMOVED;
                        cmd.src     = hmt_pkg::SRC_ENTRY;
                        cmd.cnt_dec = 1'b1;
                        cmd.rd_sel  = hmt_pkg::RD_LAST;
                    end
                end
            end
            hmt_pkg::ST_MOVE: begin
                // last entry sits in the read register: write it into the hole
                cmd.rd_en = 1'b0;
                cmd.wr_op = hmt_pkg::WR_MOVE;
            end
            default: begin
                cmd.rd_en = 1'b0;
            end
        endcase
    end

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result issued while output register busy");

    a_move_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hmt_pkg::ST_MOVE) |-> ($past(state_reg) == hmt_pkg::ST_SWEEP))
        else $error("entry move not preceded by a sweep step");

    a_finish_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != hmt_pkg::ST_IDLE && state_next == hmt_pkg::ST_IDLE)
            |-> (cmd.emit && cmd.last))
        else $error("item finished without a last beat");

endmodule

// ===== hdl/hmt_datapath.sv =====
// Datapath: entry memory, counters, configuration registers and result register.
module hmt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hmt_pkg::cmd_t                   cmd,
    output hmt_pkg::sts_t                   sts,
    input  logic                            s_mode,
    input  logic [hmt_pkg::ID_W-1:0]        s_member_id,
    input  logic [hmt_pkg::PORT_W-1:0]      s_member_port,
    input  logic [hmt_pkg::BEAT_W-1:0]      s_member_beat,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [hmt_pkg::EV_W-1:0]        m_event_res,
    output logic                            m_sweep_done,
    output logic [hmt_pkg::ID_W-1:0]        m_out_id,
    output logic [hmt_pkg::PORT_W-1:0]      m_out_port,
    output logic [hmt_pkg::BEAT_W-1:0]      m_out_beat,
    output logic                            m_last
);

    // configuration
    logic [hmt_pkg::TMO_W-1:0]  fail_tmo_reg;
    logic [hmt_pkg::TMO_W-1:0]  remove_tmo_reg;
    logic [hmt_pkg::ID_W-1:0]   own_id_reg;
    logic [hmt_pkg::PORT_W-1:0] own_port_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_tmo_reg   <= hmt_pkg::FAIL_TMO_RST;
            remove_tmo_reg <= hmt_pkg::REMOVE_TMO_RST;
            own_id_reg     <= hmt_pkg::OWN_ID_RST;
            own_port_reg   <= hmt_pkg::OWN_PORT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                hmt_pkg::CFG_FAIL_TMO:   fail_tmo_reg   <= cfg_data[hmt_pkg::TMO_W-1:0];
                hmt_pkg::CFG_REMOVE_TMO: remove_tmo_reg <= cfg_data[hmt_pkg::TMO_W-1:0];
                hmt_pkg::CFG_OWN_ID:     own_id_reg     <= cfg_data[hmt_pkg::ID_W-1:0];
                hmt_pkg::CFG_OWN_PORT:   own_port_reg   <= cfg_data[hmt_pkg::PORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // counters and index
    logic [hmt_pkg::STAMP_W-1:0] tick_count_reg, tick_count_next;
    logic [hmt_pkg::CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [hmt_pkg::CNT_W-1:0]   idx_reg, idx_next;

    always_comb begin
        tick_count_next = tick_count_reg;
        if (cmd.load && s_mode) begin
            tick_count_next = tick_count_reg + 1'b1;
        end
        entry_count_next = entry_count_reg;
        if (cmd.cnt_inc) begin
            entry_count_next = entry_count_reg + 1'b1;
        end else if (cmd.cnt_dec) begin
            entry_count_next = entry_count_reg - 1'b1;
        end
        case (cmd.idx_op)
            hmt_pkg::IDX_ZERO: idx_next = '0;
            hmt_pkg::IDX_INC:  idx_next = idx_reg + 1'b1;
            default:           idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            entry_count_reg <= '0;
            idx_reg         <= '0;
        end else begin
            tick_count_reg  <= tick_count_next;
            entry_count_reg <= entry_count_next;
            idx_reg         <= idx_next;
        end
    end

    // held item
    logic [hmt_pkg::ID_W-1:0]   item_id_reg;
    logic [hmt_pkg::PORT_W-1:0] item_port_reg;
    logic [hmt_pkg::BEAT_W-1:0] item_beat_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_id_reg   <= s_member_id;
            item_port_reg <= s_member_port;
            item_beat_reg <= s_member_beat;
        end
    end

    // entry memory, one read and one write port, registered read
    hmt_pkg::entry_t            mem [hmt_pkg::TABLE_DEPTH];
    hmt_pkg::entry_t            rd_data_reg;
    hmt_pkg::entry_t            wr_data;
    logic [hmt_pkg::CNT_W-1:0]  rd_addr_full;
    logic [hmt_pkg::IDX_W-1:0]  rd_addr;
    logic [hmt_pkg::IDX_W-1:0]  wr_addr;
    logic                       wr_en;

    always_comb begin
        case (cmd.rd_sel)
            hmt_pkg::RD_ZERO: rd_addr_full = '0;
            hmt_pkg::RD_NEXT: rd_addr_full = idx_reg + 1'b1;
            hmt_pkg::RD_LAST: rd_addr_full = entry_count_reg - 1'b1;
            default:          rd_addr_full = idx_reg;
        endcase
        // look-ahead past the end is harmless but must stay inside the array
        if (rd_addr_full < hmt_pkg::CNT_W'(hmt_pkg::TABLE_DEPTH)) begin
            rd_addr = rd_addr_full[hmt_pkg::IDX_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[hmt_pkg::IDX_W-1:0];
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            hmt_pkg::WR_REFRESH: begin
                wr_data = '{id: item_id_reg, port: item_port_reg,
                            beat: item_beat_reg, stamp: tick_count_reg};
            end
            hmt_pkg::WR_INSERT: begin
                wr_addr = entry_count_reg[hmt_pkg::IDX_W-1:0];
                wr_data = '{id: item_id_reg, port: item_port_reg,
                            beat: item_beat_reg, stamp: tick_count_reg};
            end
            hmt_pkg::WR_MOVE: begin
                wr_data = rd_data_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // status
    logic [hmt_pkg::STAMP_W-1:0] age;
    logic                        m_valid_reg;

    assign age = tick_count_reg - rd_data_reg.stamp;

    always_comb begin
        sts.is_self     = (item_id_reg == own_id_reg) && (item_port_reg == own_port_reg);
        sts.at_end      = (idx_reg >= entry_count_reg);
        sts.full        = (entry_count_reg >= hmt_pkg::CNT_W'(hmt_pkg::TABLE_DEPTH));
        sts.match       = (rd_data_reg.id == item_id_reg) && (rd_data_reg.port == item_port_reg);
        sts.newer       = (item_beat_reg > rd_data_reg.beat);
        sts.over_fail   = (age > hmt_pkg::STAMP_W'(fail_tmo_reg));
        sts.over_remove = (age > hmt_pkg::STAMP_W'(remove_tmo_reg));
        sts.out_free    = !m_valid_reg || m_ready;
    end

    // result register
    logic                        m_valid_next;
    logic [hmt_pkg::EV_W-1:0]    ev_reg;
    logic                        done_reg;
    logic [hmt_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic [hmt_pkg::PORT_W-1:0]  out_port_reg, out_port_next;
    logic [hmt_pkg::BEAT_W-1:0]  out_beat_reg, out_beat_next;
    logic                        last_reg;

    always_comb begin
        case (cmd.src)
            hmt_pkg::SRC_ITEM_NOBEAT: begin
                out_id_next   = item_id_reg;
                out_port_next = item_port_reg;
                out_beat_next = '0;
            end
            hmt_pkg::SRC_ITEM: begin
                out_id_next   = item_id_reg;
                out_port_next = item_port_reg;
                out_beat_next = item_beat_reg;
            end
            hmt_pkg::SRC_ENTRY: begin
                out_id_next   = rd_data_reg.id;
                out_port_next = rd_data_reg.port;
                out_beat_next = rd_data_reg.beat;
            end
            default: begin
                out_id_next   = '0;
                out_port_next = '0;
                out_beat_next = '0;
            end
        endcase
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            ev_reg       <= cmd.ev;
            done_reg     <= cmd.done;
            out_id_reg   <= out_id_next;
            out_port_reg <= out_port_next;
            out_beat_reg <= out_beat_next;
            last_reg     <= cmd.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_res  = ev_reg;
    assign m_sweep_done = done_reg;
    assign m_out_id     = out_id_reg;
    assign m_out_port   = out_port_reg;
    assign m_out_beat   = out_beat_reg;
    assign m_last       = last_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= hmt_pkg::CNT_W'(hmt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_idx_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= entry_count_reg)
        else $error("scan index beyond entry count");

    a_tick_only_on_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_count_reg != $past(tick_count_reg)) |-> $past(cmd.load && s_mode))
        else $error("tick count moved without a tick beat");

endmodule
